>>> rtl/bios_disk_service_unit_macros.svh
// Assertion macros used by the checker file of the disk service unit.
`ifndef BIOS_DISK_SERVICE_UNIT_MACROS_SVH
`define BIOS_DISK_SERVICE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BDSU_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BDSU_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/bdsu_pkg.sv
// Shared constants, codes and types of the disk service unit.
package bdsu_pkg;

    localparam int DRIVE_W      = 8;
    localparam int STATUS_SLOTS = 2 ** DRIVE_W;
    localparam int DRIVE_SLOTS  = 256;
    localparam int SLOT_W       = (DRIVE_SLOTS > 1) ? $clog2(DRIVE_SLOTS) : 1;
    localparam int SECTOR_BYTES = 512;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

    // hard disk cylinders = bytes / (63 * 16 * 512): shift out 16*512, then /63
    localparam int HD_DIV_SHIFT = $clog2(16 * SECTOR_BYTES);
    localparam int MUL_W        = 20;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int RECIP_SHIFT  = 25;
    localparam logic [MUL_W-1:0] RECIP_63 = MUL_W'(((2 ** RECIP_SHIFT) + 62) / 63);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_EJECT  = 2'd1;
    localparam logic [1:0] MODE_REQ    = 2'd2;

    localparam logic [7:0] FN_RESET  = 8'h00;
    localparam logic [7:0] FN_STATUS = 8'h01;
    localparam logic [7:0] FN_READ   = 8'h02;
    localparam logic [7:0] FN_WRITE  = 8'h03;
    localparam logic [7:0] FN_VERIFY = 8'h04;
    localparam logic [7:0] FN_FORMAT = 8'h05;
    localparam logic [7:0] FN_PARAMS = 8'h08;

    localparam logic [7:0] ST_OK        = 8'h00;
    localparam logic [7:0] ST_BAD_CMD   = 8'h01;
    localparam logic [7:0] ST_NOT_READY = 8'hAA;

    localparam logic [1:0] XFER_NONE  = 2'd0;
    localparam logic [1:0] XFER_READ  = 2'd1;
    localparam logic [1:0] XFER_WRITE = 2'd2;

    localparam logic [7:0] HD_BASE    = 8'h80;
    localparam logic [5:0] HD_SECTORS = 6'd63;
    localparam logic [4:0] HD_HEADS   = 5'd16;

    localparam logic [31:0] FLOPPY_160K  = 32'd163840;
    localparam logic [31:0] FLOPPY_360K  = 32'd368640;
    localparam logic [31:0] FLOPPY_720K  = 32'd737280;
    localparam logic [31:0] FLOPPY_1200K = 32'd1228800;

    localparam logic [7:0] FLOPPY_TYPE  = 8'd4;
    localparam logic [7:0] FLOPPY_COUNT = 8'd2;

    typedef struct packed {
        logic [31:0] size;
        logic [13:0] cyls;
        logic [4:0]  heads;
        logic [5:0]  sects;
    } geo_t;

    typedef struct packed {
        logic               rd_en;
        logic [DRIVE_W-1:0] rd_idx;
        logic               geo_we;
        logic               pres_set;
        logic               pres_clr;
        logic               st_we;
        logic [DRIVE_W-1:0] wr_idx;
        geo_t               geo;
        logic [7:0]         st_ah;
        logic               st_cf;
    } tbl_req_t;

    typedef struct packed {
        logic       present;
        geo_t       geo;
        logic [7:0] st_ah;
        logic       st_cf;
    } tbl_rd_t;

endpackage

>>> rtl/bios_disk_service_unit.sv
// Top level of the disk service unit: sequencer, shared multiplier and drive table.
//
//  channel   | handshake          | fields
//  ----------+--------------------+-----------------------------------------------
//  request   | start / busy       | mode, drive, image_bytes, function_code, ...
//  result    | done (one cycle)   | status_ah, carry, out_*, transfer_kind, ...
//
// Sequence: a request is taken when start is high and busy is low; done then pulses
// for one cycle. Eject and most services finish after the table read, an image
// insert after one pass through the shared multiplier, and a read or write that
// reaches the offset check after two dependent multiplies, then add and compare.
// Reset: the present bits and status valid bits clear at once, no sweep.
// The receiver cannot stall; busy is low again in the cycle done is high.
module bios_disk_service_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [7:0]  drive,
    input  logic [31:0] image_bytes,
    input  logic [7:0]  function_code,
    input  logic [7:0]  count_in,
    input  logic [7:0]  bl_in,
    input  logic [7:0]  cyl_low_in,
    input  logic [7:0]  sector_in,
    input  logic [7:0]  head_in,
    input  logic [15:0] buffer_segment,
    input  logic [15:0] buffer_offset,
    output logic        done,
    output logic [7:0]  status_ah,
    output logic        carry,
    output logic [7:0]  out_al,
    output logic [7:0]  out_ch,
    output logic [7:0]  out_cl,
    output logic [7:0]  out_dh,
    output logic [7:0]  out_dl,
    output logic [7:0]  out_bl,
    output logic [1:0]  transfer_kind,
    output logic [31:0] image_byte_offset,
    output logic [20:0] memory_address,
    output logic        status_to_bda
);
    import bdsu_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;  // divide image size through multiplier
    localparam logic [2:0] S_INSWR = 3'd2;  // write geometry, finish insert
    localparam logic [2:0] S_LOOK  = 3'd3;  // table data valid, most services finish
    localparam logic [2:0] S_MUL2  = 3'd4;  // (cyl*heads + head) * sectors
    localparam logic [2:0] S_LBA   = 3'd5;  // logical sector to byte offset
    localparam logic [2:0] S_CHK   = 3'd6;  // offset vs image size, clip count

    typedef struct packed {
        logic [7:0]  ah;
        logic        cf;
        logic [7:0]  al;
        logic [7:0]  ch;
        logic [7:0]  cl;
        logic [7:0]  dh;
        logic [7:0]  dl;
        logic [7:0]  bl;
        logic [1:0]  kind;
        logic [31:0] ofs;
        logic [20:0] addr;
        logic        bda;
    } res_t;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  hd_count_reg, hd_count_next;
    logic [31:0] fo_reg, fo_next;
    logic        done_reg;
    res_t        res_reg;

    // captured request
    logic [1:0]  mode_reg;
    logic [7:0]  drv_reg;
    logic [31:0] bytes_reg;
    logic [7:0]  fn_reg;
    logic [7:0]  al_reg;
    logic [7:0]  bl_reg;
    logic [7:0]  ch_reg;
    logic [7:0]  cl_reg;
    logic [7:0]  dh_reg;
    logic [15:0] seg_reg;
    logic [15:0] off_reg;

    logic              accept;
    logic              fin;
    logic              inslot;
    logic              present;
    logic              xfer_go;
    logic [5:0]        sect;
    logic [9:0]        cyl;
    logic              mul_en;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;
    tbl_req_t          tq;
    tbl_rd_t           trd;
    geo_t              new_geo;
    res_t              rq;
    res_t              res;

    // avail/clip helpers
    logic [31:0] room;
    logic        fits;
    logic [22:0] avail;
    logic [13:0] cm;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign inslot  = ({1'b0, drv_reg} < 9'(DRIVE_SLOTS));
    assign present = inslot && trd.present;
    assign sect    = cl_reg[5:0];
    assign cyl     = {cl_reg[7:6], ch_reg};
    assign xfer_go = ((fn_reg == FN_READ) || (fn_reg == FN_WRITE)) && present
                     && (sect != 6'd0);

    bdsu_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    bdsu_tbl u_tbl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tq),
        .rd    (trd)
    );

    // geometry for an insert; hard disk cylinders come from the reciprocal product
    always_comb
    begin
        new_geo.size = bytes_reg;
        if (drv_reg >= HD_BASE)
        begin
            new_geo.cyls  = prod[RECIP_SHIFT +: 14];
            new_geo.heads = HD_HEADS;
            new_geo.sects = HD_SECTORS;
        end
        else if (bytes_reg <= FLOPPY_160K)
        begin
            new_geo.cyls  = 14'd40;
            new_geo.heads = 5'd1;
            new_geo.sects = 6'd8;
        end
        else if (bytes_reg <= FLOPPY_360K)
        begin
            new_geo.cyls  = 14'd40;
            new_geo.heads = 5'd2;
            new_geo.sects = 6'd9;
        end
        else if (bytes_reg <= FLOPPY_720K)
        begin
            new_geo.cyls  = 14'd80;
            new_geo.heads = 5'd2;
            new_geo.sects = 6'd9;
        end
        else if (bytes_reg <= FLOPPY_1200K)
        begin
            new_geo.cyls  = 14'd80;
            new_geo.heads = 5'd2;
            new_geo.sects = 6'd15;
        end
        else
        begin
            new_geo.cyls  = 14'd80;
            new_geo.heads = 5'd2;
            new_geo.sects = 6'd18;
        end
    end

    // service result; the transfer part is only filled in at the offset check
    assign room  = trd.geo.size - fo_reg;
    assign fits  = (fo_reg <= trd.geo.size);
    assign avail = room[31:SECTOR_SHIFT];
    assign cm    = trd.geo.cyls - 14'd1;

    always_comb
    begin
        rq      = '0;
        rq.ah   = fn_reg;
        rq.cf   = 1'b0;
        rq.al   = al_reg;
        rq.ch   = ch_reg;
        rq.cl   = cl_reg;
        rq.dh   = dh_reg;
        rq.dl   = drv_reg;
        rq.bl   = bl_reg;
        rq.kind = XFER_NONE;
        rq.bda  = (fn_reg != FN_STATUS) && (drv_reg >= HD_BASE);
        case (fn_reg)
            FN_RESET, FN_VERIFY, FN_FORMAT:
            begin
                rq.ah = ST_OK;
            end
            FN_STATUS:
            begin
                rq.ah = trd.st_ah;
                rq.cf = trd.st_cf;
            end
            FN_READ, FN_WRITE:
            begin
                if (!present)
                begin
                    rq.ah = ST_BAD_CMD;
                    rq.cf = 1'b1;
                end
                else
                begin
                    rq.ah = ST_OK;
                    if ((state_reg == S_CHK) && fits)
                    begin
                        rq.ofs  = fo_reg;
                        rq.addr = {1'b0, seg_reg, 4'h0} + 21'(off_reg);
                        if (fn_reg == FN_READ)
                        begin
                            rq.kind = XFER_READ;
                            if (avail < 23'(al_reg))
                            begin
                                rq.al = avail[7:0];
                            end
                        end
                        else
                        begin
                            rq.kind = XFER_WRITE;
                        end
                    end
                end
            end
            FN_PARAMS:
            begin
                if (!present)
                begin
                    rq.ah = ST_NOT_READY;
                    rq.cf = 1'b1;
                end
                else
                begin
                    rq.ah = ST_OK;
                    rq.ch = cm[7:0];
                    rq.cl = {cm[9:8], trd.geo.sects};
                    rq.dh = {3'b000, trd.geo.heads} - 8'd1;
                    if (drv_reg < HD_BASE)
                    begin
                        rq.bl = FLOPPY_TYPE;
                        rq.dl = FLOPPY_COUNT;
                    end
                    else
                    begin
                        rq.dl = hd_count_reg;
                    end
                end
            end
            default:
            begin
                rq.cf = 1'b1;
            end
        endcase
    end

    // insert, eject and unknown modes report all zero
    assign res = (mode_reg == MODE_REQ) ? rq : '0;

    // sequencer: drives the multiplier and the table ports
    always_comb
    begin
        state_next    = state_reg;
        hd_count_next = hd_count_reg;
        fo_next       = fo_reg;
        fin           = 1'b0;
        mul_en        = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        tq            = '0;
        tq.rd_en      = accept;
        tq.rd_idx     = drive;
        tq.wr_idx     = drv_reg;
        tq.geo        = new_geo;
        tq.st_ah      = rq.ah;
        tq.st_cf      = rq.cf;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (mode == MODE_INSERT) ? S_INS : S_LOOK;
                end
            end
            S_INS:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(bytes_reg[31:HD_DIV_SHIFT]);
                mul_b      = RECIP_63;
                state_next = S_INSWR;
            end
            S_INSWR:
            begin
                fin        = 1'b1;
                state_next = S_IDLE;
                if (inslot)
                begin
                    tq.geo_we   = 1'b1;
                    tq.pres_set = 1'b1;
                    if (drv_reg >= HD_BASE)
                    begin
                        hd_count_next = hd_count_reg + 8'd1;
                    end
                end
            end
            S_LOOK:
            begin
                if ((mode_reg == MODE_REQ) && xfer_go)
                begin
                    mul_en     = 1'b1;
                    mul_a      = MUL_W'(cyl);
                    mul_b      = MUL_W'(trd.geo.heads);
                    state_next = S_MUL2;
                end
                else
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                    if ((mode_reg == MODE_EJECT) && inslot)
                    begin
                        tq.pres_clr = 1'b1;
                    end
                end
            end
            S_MUL2:
            begin
                mul_en     = 1'b1;
                mul_a      = prod[MUL_W-1:0] + MUL_W'(dh_reg);
                mul_b      = MUL_W'(trd.geo.sects);
                state_next = S_LBA;
            end
            S_LBA:
            begin
                fo_next    = (prod[31:0] + 32'(sect) - 32'd1) << SECTOR_SHIFT;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // every service but status read updates the record
        if (fin && (mode_reg == MODE_REQ) && (fn_reg != FN_STATUS))
        begin
            tq.st_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            hd_count_reg <= 8'd0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hd_count_reg <= hd_count_next;
            done_reg     <= fin;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fo_reg <= fo_next;
        if (accept)
        begin
            mode_reg  <= mode;
            drv_reg   <= drive;
            bytes_reg <= image_bytes;
            fn_reg    <= function_code;
            al_reg    <= count_in;
            bl_reg    <= bl_in;
            ch_reg    <= cyl_low_in;
            cl_reg    <= sector_in;
            dh_reg    <= head_in;
            seg_reg   <= buffer_segment;
            off_reg   <= buffer_offset;
        end
        if (fin)
        begin
            res_reg <= res;
        end
    end

    assign done              = done_reg;
    assign status_ah         = res_reg.ah;
    assign carry             = res_reg.cf;
    assign out_al            = res_reg.al;
    assign out_ch            = res_reg.ch;
    assign out_cl            = res_reg.cl;
    assign out_dh            = res_reg.dh;
    assign out_dl            = res_reg.dl;
    assign out_bl            = res_reg.bl;
    assign transfer_kind     = res_reg.kind;
    assign image_byte_offset = res_reg.ofs;
    assign memory_address    = res_reg.addr;
    assign status_to_bda     = res_reg.bda;

endmodule

>>> rtl/bdsu_mul.sv
// Shared multiplier with a registered product.
module bdsu_mul (
    input  logic                          clk,
    input  logic                          en,
    input  logic [bdsu_pkg::MUL_W-1:0]    a,
    input  logic [bdsu_pkg::MUL_W-1:0]    b,
    output logic [bdsu_pkg::PROD_W-1:0]   prod
);
    import bdsu_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/bdsu_tbl.sv
// Drive geometry table and last-status record with registered reads.
module bdsu_tbl (
    input  logic               clk,
    input  logic               rst_n,
    input  bdsu_pkg::tbl_req_t req,
    output bdsu_pkg::tbl_rd_t  rd
);
    import bdsu_pkg::*;

    logic [DRIVE_SLOTS-1:0]  present_reg;
    logic [STATUS_SLOTS-1:0] st_vld_reg;
    geo_t                    geo_mem [DRIVE_SLOTS];
    logic [8:0]              st_mem  [STATUS_SLOTS];

    logic       present_q_reg;
    logic       st_vld_q_reg;
    geo_t       geo_q_reg;
    logic [8:0] st_q_reg;

    logic [SLOT_W-1:0] wslot;
    logic [SLOT_W-1:0] rslot;

    assign wslot = req.wr_idx[SLOT_W-1:0];
    assign rslot = req.rd_idx[SLOT_W-1:0];

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= '0;
            st_vld_reg    <= '0;
            present_q_reg <= 1'b0;
            st_vld_q_reg  <= 1'b0;
        end
        else
        begin
            if (req.pres_set)
            begin
                present_reg[wslot] <= 1'b1;
            end
            else if (req.pres_clr)
            begin
                present_reg[wslot] <= 1'b0;
            end
            if (req.st_we)
            begin
                st_vld_reg[req.wr_idx] <= 1'b1;
            end
            if (req.rd_en)
            begin
                present_q_reg <= present_reg[rslot];
                st_vld_q_reg  <= st_vld_reg[req.rd_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.geo_we)
        begin
            geo_mem[wslot] <= req.geo;
        end
        if (req.rd_en)
        begin
            geo_q_reg <= geo_mem[rslot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.st_we)
        begin
            st_mem[req.wr_idx] <= {req.st_ah, req.st_cf};
        end
        if (req.rd_en)
        begin
            st_q_reg <= st_mem[req.rd_idx];
        end
    end

    assign rd.present = present_q_reg;
    assign rd.geo     = geo_q_reg;
    assign rd.st_ah   = st_vld_q_reg ? st_q_reg[8:1] : 8'h00;
    assign rd.st_cf   = st_vld_q_reg ? st_q_reg[0]   : 1'b0;

endmodule

>>> rtl/bdsu_checker.sv
// Port-level assertions for the disk service unit and their bind.
`include "bios_disk_service_unit_macros.svh"

module bdsu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [7:0]  status_ah,
    input logic        carry,
    input logic [1:0]  transfer_kind,
    input logic [31:0] image_byte_offset,
    input logic [20:0] memory_address
);
    import bdsu_pkg::*;

    `BDSU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request taken but busy stayed low")
    `BDSU_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
    `BDSU_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
    `BDSU_ASSERT_NOW(a_no_xfer_zero,
        done && (transfer_kind == XFER_NONE),
        (image_byte_offset == 32'd0) && (memory_address == 21'd0),
        "offset or address set without a transfer")
    `BDSU_ASSERT_NOW(a_xfer_ok, done && (transfer_kind != XFER_NONE),
        (status_ah == ST_OK) && !carry, "transfer reported with an error status")

endmodule

bind bios_disk_service_unit bdsu_checker u_bdsu_checker (.*);

>>> tb/sv/bios_disk_service_unit_tb.sv
// Testbench for the disk service unit: directed and random requests checked against a predictor.
module bios_disk_service_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdsu_pkg::*;

    // Mode 3 is undefined: accepted, no state change, all-zero reply.
    localparam logic [1:0] MODE_NONE = 2'd3;
    // Not a service the unit knows: carry set, AH echoed.
    localparam logic [7:0] FN_UNKNOWN = 8'h41;
    localparam logic [31:0] HD_CYL_BYTES = 32'(63 * 16 * SECTOR_BYTES);
    localparam int unsigned GAP_MAX = 19;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned ERRORS_SHOWN = 10;

    // Drives that random traffic keeps coming back to, so reads find images.
    localparam logic [7:0] DRIVE_POOL [8] =
        '{8'h00, 8'h01, 8'h02, 8'h7F, 8'h80, 8'h81, 8'hC3, 8'hFF};
    // Reads and writes listed twice to weight them.
    localparam logic [7:0] SERVICE_MIX [9] =
        '{FN_RESET, FN_STATUS, FN_READ, FN_WRITE, FN_READ, FN_WRITE,
          FN_VERIFY, FN_FORMAT, FN_PARAMS};
    localparam logic [31:0] FLOPPY_LIMITS [4] =
        '{FLOPPY_160K, FLOPPY_360K, FLOPPY_720K, FLOPPY_1200K};

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  drive;
        logic [31:0] image_bytes;
        logic [7:0]  function_code;
        logic [7:0]  count_in;
        logic [7:0]  bl_in;
        logic [7:0]  cyl_low_in;
        logic [7:0]  sector_in;
        logic [7:0]  head_in;
        logic [15:0] buffer_segment;
        logic [15:0] buffer_offset;
    } request_t;

    typedef struct packed {
        logic [7:0]  status_ah;
        logic        carry;
        logic [7:0]  out_al;
        logic [7:0]  out_ch;
        logic [7:0]  out_cl;
        logic [7:0]  out_dh;
        logic [7:0]  out_dl;
        logic [7:0]  out_bl;
        logic [1:0]  transfer_kind;
        logic [31:0] image_byte_offset;
        logic [20:0] memory_address;
        logic        status_to_bda;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [7:0]  drive;
    logic [31:0] image_bytes;
    logic [7:0]  function_code;
    logic [7:0]  count_in;
    logic [7:0]  bl_in;
    logic [7:0]  cyl_low_in;
    logic [7:0]  sector_in;
    logic [7:0]  head_in;
    logic [15:0] buffer_segment;
    logic [15:0] buffer_offset;
    logic        done;
    logic [7:0]  status_ah;
    logic        carry;
    logic [7:0]  out_al;
    logic [7:0]  out_ch;
    logic [7:0]  out_cl;
    logic [7:0]  out_dh;
    logic [7:0]  out_dl;
    logic [7:0]  out_bl;
    logic [1:0]  transfer_kind;
    logic [31:0] image_byte_offset;
    logic [20:0] memory_address;
    logic        status_to_bda;

    // Predictor copy of the drive table and the per-drive status record.
    logic        drv_present [256];
    logic [31:0] drv_size    [256];
    logic [13:0] drv_cyls    [256];
    logic [4:0]  drv_heads   [256];
    logic [5:0]  drv_sects   [256];
    logic [7:0]  rec_status  [256];
    logic        rec_carry   [256];
    logic [7:0]  hd_count;

    reply_t      reply_q [$];
    int unsigned mismatches;
    bit          back_to_back;   // when set, the sender never pauses

    bios_disk_service_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .drive            (drive),
        .image_bytes      (image_bytes),
        .function_code    (function_code),
        .count_in         (count_in),
        .bl_in            (bl_in),
        .cyl_low_in       (cyl_low_in),
        .sector_in        (sector_in),
        .head_in          (head_in),
        .buffer_segment   (buffer_segment),
        .buffer_offset    (buffer_offset),
        .done             (done),
        .status_ah        (status_ah),
        .carry            (carry),
        .out_al           (out_al),
        .out_ch           (out_ch),
        .out_cl           (out_cl),
        .out_dh           (out_dh),
        .out_dl           (out_dl),
        .out_bl           (out_bl),
        .transfer_kind    (transfer_kind),
        .image_byte_offset(image_byte_offset),
        .memory_address   (memory_address),
        .status_to_bda    (status_to_bda)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Works out the reply to one accepted request and advances the drive table.
    function automatic reply_t predict_service(request_t r);
        reply_t      y;
        logic [7:0]  d;
        logic [7:0]  ah, al, ch, cl, dh, dl, bl;
        logic        cf;
        logic [15:0] cyl, cyl_m1;
        logic [31:0] lba, byte_ofs, avail;
        d = r.drive;
        y = '0;
        if (r.mode == MODE_INSERT) begin
            drv_present[d] = 1'b1;
            drv_size[d]    = r.image_bytes;
            if (d >= HD_BASE) begin
                drv_sects[d] = HD_SECTORS;
                drv_heads[d] = HD_HEADS;
                drv_cyls[d]  = 14'(r.image_bytes / HD_CYL_BYTES);
                hd_count     = hd_count + 8'd1;   // counts repeats too, wraps
            end else begin
                // floppy geometry picked by the smallest format that holds the image
                drv_cyls[d] = 14'd80; drv_heads[d] = 5'd2; drv_sects[d] = 6'd18;
                if (r.image_bytes <= FLOPPY_1200K) drv_sects[d] = 6'd15;
                if (r.image_bytes <= FLOPPY_720K)  drv_sects[d] = 6'd9;
                if (r.image_bytes <= FLOPPY_360K)  drv_cyls[d]  = 14'd40;
                if (r.image_bytes <= FLOPPY_160K) begin
                    drv_sects[d] = 6'd8;
                    drv_heads[d] = 5'd1;
                end
            end
            return y;
        end
        if (r.mode == MODE_EJECT) begin
            drv_present[d] = 1'b0;   // geometry stays behind
            return y;
        end
        if (r.mode != MODE_REQ)
            return y;

        ah = r.function_code;  cf = 1'b0;
        al = r.count_in;       bl = r.bl_in;
        ch = r.cyl_low_in;     cl = r.sector_in;
        dh = r.head_in;        dl = d;
        case (r.function_code)
            FN_RESET, FN_VERIFY, FN_FORMAT: begin
                ah = ST_OK;
            end
            FN_STATUS: begin
                ah = rec_status[d];
                cf = rec_carry[d];
            end
            FN_READ, FN_WRITE: begin
                if (!drv_present[d]) begin
                    ah = ST_BAD_CMD;
                    cf = 1'b1;
                end else begin
                    ah  = ST_OK;
                    cyl = {6'd0, r.sector_in[7:6], r.cyl_low_in};
                    if (r.sector_in[5:0] != 6'd0) begin
                        lba = (32'(cyl) * 32'(drv_heads[d]) + 32'(r.head_in))
                              * 32'(drv_sects[d]) + 32'(r.sector_in[5:0]) - 32'd1;
                        byte_ofs = lba * 32'(SECTOR_BYTES);
                        if (byte_ofs <= drv_size[d]) begin
                            y.image_byte_offset = byte_ofs;
                            y.memory_address = 21'({r.buffer_segment, 4'd0})
                                               + 21'(r.buffer_offset);
                            if (r.function_code == FN_READ) begin
                                // clip the read to whole sectors left in the image
                                avail = (drv_size[d] - byte_ofs) / 32'(SECTOR_BYTES);
                                y.transfer_kind = XFER_READ;
                                if (avail < 32'(al))
                                    al = avail[7:0];
                            end else begin
                                y.transfer_kind = XFER_WRITE;
                            end
                        end
                    end
                end
            end
            FN_PARAMS: begin
                if (!drv_present[d]) begin
                    ah = ST_NOT_READY;
                    cf = 1'b1;
                end else begin
                    ah     = ST_OK;
                    cyl_m1 = 16'(drv_cyls[d]) - 16'd1;
                    ch     = cyl_m1[7:0];
                    cl     = {cyl_m1[9:8], drv_sects[d]};
                    dh     = 8'(drv_heads[d]) - 8'd1;
                    if (d < HD_BASE) begin
                        bl = FLOPPY_TYPE;
                        dl = FLOPPY_COUNT;
                    end else begin
                        dl = hd_count;
                    end
                end
            end
            default: begin
                cf = 1'b1;
            end
        endcase
        if (r.function_code != FN_STATUS) begin
            rec_status[d]   = ah;
            rec_carry[d]    = cf;
            y.status_to_bda = d[7];
        end
        y.status_ah = ah;
        y.carry     = cf;
        y.out_al    = al;
        y.out_ch    = ch;
        y.out_cl    = cl;
        y.out_dh    = dh;
        y.out_dl    = dl;
        y.out_bl    = bl;
        return y;
    endfunction

    // Drive one request, hold it until taken, then idle for a random gap unless back_to_back is set.
    task automatic send_request(request_t r);
        int unsigned gap;
        start          <= 1'b1;
        mode           <= r.mode;
        drive          <= r.drive;
        image_bytes    <= r.image_bytes;
        function_code  <= r.function_code;
        count_in       <= r.count_in;
        bl_in          <= r.bl_in;
        cyl_low_in     <= r.cyl_low_in;
        sector_in      <= r.sector_in;
        head_in        <= r.head_in;
        buffer_segment <= r.buffer_segment;
        buffer_offset  <= r.buffer_offset;
        do
            @(posedge clk);
        while (busy);
        reply_q.push_back(predict_service(r));
        gap = back_to_back ? 0 : $urandom_range(0, GAP_MAX);
        // start stays high for a zero gap; the next request reuses it
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Request with random registers and buffer; callers set what matters.
    function automatic request_t base_request(logic [1:0] m, logic [7:0] d, logic [7:0] fn);
        request_t r;
        r.mode           = m;
        r.drive          = d;
        r.function_code  = fn;
        r.image_bytes    = $urandom;
        r.count_in       = 8'($urandom);
        r.bl_in          = 8'($urandom);
        r.cyl_low_in     = 8'($urandom);
        r.sector_in      = 8'($urandom);
        r.head_in        = 8'($urandom);
        r.buffer_segment = 16'($urandom);
        r.buffer_offset  = 16'($urandom);
        return r;
    endfunction

    task automatic insert_image(logic [7:0] d, logic [31:0] bytes);
        request_t r;
        r = base_request(MODE_INSERT, d, 8'($urandom));
        r.image_bytes = bytes;
        send_request(r);
    endtask

    task automatic run_service(logic [7:0] d, logic [7:0] fn, logic [7:0] al,
                               logic [9:0] cyl, logic [5:0] sect, logic [7:0] head);
        request_t r;
        r = base_request(MODE_REQ, d, fn);
        r.count_in   = al;
        r.cyl_low_in = cyl[7:0];
        r.sector_in  = {cyl[9:8], sect};
        r.head_in    = head;
        send_request(r);
    endtask

    function automatic logic [31:0] random_image_size(logic [7:0] d);
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return FLOPPY_LIMITS[$urandom_range(0, 3)] + $urandom_range(0, 1);
            2:       return $urandom_range(0, 2000000);
            default: return (d >= HD_BASE) ? $urandom_range(0, 40000000)
                                           : $urandom_range(1000, 1500000);
        endcase
    endfunction

    // Mostly well-formed traffic on a small drive pool; CHS often inside the geometry.
    function automatic request_t random_request();
        request_t    r;
        logic [7:0]  d;
        int unsigned pick, cyl_span, cyl;
        pick = $urandom_range(0, 99);
        d = ($urandom_range(0, 3) != 0) ? DRIVE_POOL[$urandom_range(0, 7)] : 8'($urandom);
        r = base_request(MODE_REQ, d, SERVICE_MIX[$urandom_range(0, 8)]);
        if (pick < 10) begin
            r.mode        = MODE_INSERT;
            r.image_bytes = random_image_size(d);
        end else if (pick < 14) begin
            r.mode = MODE_EJECT;
        end else if (pick < 16) begin
            r.mode = MODE_NONE;
        end else begin
            if ($urandom_range(0, 9) == 0)
                r.function_code = 8'($urandom);
            if ((r.function_code == FN_READ || r.function_code == FN_WRITE)
                && drv_present[d] && $urandom_range(0, 4) != 0) begin
                cyl_span = (drv_cyls[d] == 0) ? 1 : ((drv_cyls[d] > 1024) ? 1024 : drv_cyls[d]);
                // lean on the last cylinder so clipping at the image end shows up
                cyl = ($urandom_range(0, 2) == 0) ? cyl_span - 1 : $urandom_range(0, cyl_span - 1);
                r.cyl_low_in = cyl[7:0];
                r.sector_in  = {cyl[9:8], 6'($urandom_range(1, drv_sects[d]))};
                r.head_in    = 8'($urandom_range(0, drv_heads[d] - 1));
            end
        end
        return r;
    endfunction

    // Status, transfer and parameter requests before any image is present.
    task automatic test_empty_drives();
        run_service(8'h00, FN_STATUS, 8'h00, 10'd0, 6'd1, 8'h00);
        run_service(8'h00, FN_READ,   8'h01, 10'd0, 6'd1, 8'h00);
        run_service(8'h80, FN_PARAMS, 8'h00, 10'd0, 6'd0, 8'h00);
        run_service(8'h80, FN_STATUS, 8'h00, 10'd0, 6'd0, 8'h00);
    endtask

    // Floppy sizes at the 160K and 1200K boundaries and an oversize image, empty and full-size hard disks, then params.
    task automatic test_geometry();
        insert_image(8'h00, FLOPPY_160K);
        insert_image(8'h01, FLOPPY_160K + 32'd1);
        insert_image(8'h02, FLOPPY_1200K);
        insert_image(8'h7F, 32'hFFFF_FFFF);
        insert_image(8'h80, 32'd0);
        insert_image(8'hFF, 32'hFFFF_FFFF);
        run_service(8'h00, FN_PARAMS, 8'h00, 10'd0, 6'd0, 8'h00);
        run_service(8'h01, FN_PARAMS, 8'h00, 10'd0, 6'd0, 8'h00);
        run_service(8'h7F, FN_PARAMS, 8'h00, 10'd0, 6'd0, 8'h00);
        run_service(8'h80, FN_PARAMS, 8'h00, 10'd0, 6'd0, 8'h00);   // cylinders-1 wraps
        run_service(8'hFF, FN_PARAMS, 8'h00, 10'd0, 6'd0, 8'h00);
    endtask

    // Drive 0 holds a 160K image: 40 cylinders, 1 head, 8 sectors.
    task automatic test_transfer_edges();
        run_service(8'h00, FN_READ,  8'hFF, 10'd0,   6'd0,  8'h00);   // sector 0: no move
        run_service(8'h00, FN_READ,  8'hFF, 10'd39,  6'd8,  8'h00);   // last sector, clip to 1
        run_service(8'h00, FN_READ,  8'h05, 10'd40,  6'd1,  8'h00);   // offset at image end
        run_service(8'h00, FN_WRITE, 8'hFF, 10'h3FF, 6'd63, 8'hFF);   // far past the end
        run_service(8'h00, FN_WRITE, 8'hFF, 10'd0,   6'd1,  8'h00);
    endtask

    task automatic test_misc_services();
        request_t r;
        run_service(8'h81, FN_RESET,   8'h12, 10'd0, 6'd0, 8'h00);
        run_service(8'h81, FN_VERIFY,  8'h12, 10'd0, 6'd0, 8'h00);
        run_service(8'h81, FN_FORMAT,  8'h12, 10'd0, 6'd0, 8'h00);
        run_service(8'hFE, FN_UNKNOWN, 8'h00, 10'd0, 6'd0, 8'h00);
        run_service(8'hFE, FN_STATUS,  8'h00, 10'd0, 6'd0, 8'h00);
        send_request(base_request(MODE_EJECT, 8'h00, 8'($urandom)));
        run_service(8'h00, FN_READ,    8'h01, 10'd0, 6'd1, 8'h00);   // ejected drive
        r = base_request(MODE_NONE, 8'h80, 8'($urandom));
        send_request(r);
    endtask

    // Enough hard disk inserts that the hard disk count wraps past 255.
    task automatic test_hard_disk_count_wrap();
        logic [7:0] d;
        d = HD_BASE;
        back_to_back = 1'b1;
        for (int i = 0; i < 260; i++) begin
            d = HD_BASE + 8'($urandom_range(0, 127));
            insert_image(d, $urandom_range(0, 20000000));
            if (i == 130)
                back_to_back = 1'b0;
        end
        run_service(d, FN_PARAMS, 8'h00, 10'd0, 6'd0, 8'h00);
        back_to_back = 1'b0;
    endtask

    // Random traffic, alternating runs with and without sender pauses.
    task automatic test_random_traffic(int unsigned n_items);
        int unsigned run_left;
        run_left = 0;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (run_left == 0) begin
                back_to_back = ($urandom_range(0, 3) == 0);
                run_left     = $urandom_range(20, 80);
            end
            run_left--;
            send_request(random_request());
        end
        back_to_back = 1'b0;
    endtask

    // Every done pulse is compared with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        reply_t got, want;
        if (rst_n && done) begin
            got = '{status_ah, carry, out_al, out_ch, out_cl, out_dh, out_dl, out_bl,
                    transfer_kind, image_byte_offset, memory_address, status_to_bda};
            if (reply_q.size() == 0) begin
                mismatches++;
                if (mismatches <= ERRORS_SHOWN)
                    $display("unexpected reply at %0t: %p", $realtime, got);
            end else begin
                want = reply_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= ERRORS_SHOWN)
                        $display("reply mismatch at %0t\n  expected %p\n  actual   %p",
                                 $realtime, want, got);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("** bios_disk_service_unit: FAILED **");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        mode           = MODE_INSERT;
        drive          = '0;
        image_bytes    = '0;
        function_code  = '0;
        count_in       = '0;
        bl_in          = '0;
        cyl_low_in     = '0;
        sector_in      = '0;
        head_in        = '0;
        buffer_segment = '0;
        buffer_offset  = '0;
        mismatches     = 0;
        back_to_back   = 1'b0;
        hd_count       = '0;
        for (int i = 0; i < 256; i++) begin
            drv_present[i] = 1'b0;
            drv_size[i]    = '0;
            drv_cyls[i]    = '0;
            drv_heads[i]   = '0;
            drv_sects[i]   = '0;
            rec_status[i]  = '0;
            rec_carry[i]   = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_drives();
        test_geometry();
        test_transfer_edges();
        test_misc_services();
        test_hard_disk_count_wrap();
        test_random_traffic(1000);

        start <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && reply_q.size() == 0)
            $display("** bios_disk_service_unit: PASSED **");
        else
            $display("** bios_disk_service_unit: FAILED **");
        $finish;
    end

endmodule

>>> bios_disk_service_unit.f
+incdir+rtl
rtl/bdsu_pkg.sv
rtl/bdsu_mul.sv
rtl/bdsu_tbl.sv
rtl/bios_disk_service_unit.sv
rtl/bdsu_checker.sv
tb/sv/bios_disk_service_unit_tb.sv
